/* src/assert_macros.svh */
// assertion macros used by the checker module of the cache model
// depends on a clk and an active-low arst_n in the scope that expands them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define SACM_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, quiet while reset is held
`define SACM_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/sacm_pkg.sv */
// shared widths, codes and field positions of the cache hit/miss model
// no dependencies; imported by the top level and its checker
`default_nettype none

package sacm_pkg;

	// stream field widths
	localparam int ADDR_FIELD_W = 64;
	localparam int OP_W         = 2;
	localparam int STAMP_W      = 64;
	localparam int TOTAL_W      = 32;
	localparam int TOTALS_W     = 3 * TOTAL_W;
	localparam int FLAGS_W      = 3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// result flag positions in m_tuser
	localparam int FLAG_HIT   = 0;
	localparam int FLAG_MISS  = 1;
	localparam int FLAG_EVICT = 2;

	// access kinds
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// configuration registers
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 6;
	localparam int SET_BITS_W    = 3;
	localparam int OFFSET_BITS_W = 6;
	localparam int WAYS_W        = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

endpackage

`default_nettype wire

/* src/sacm_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module sacm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/set_assoc_cache_mru_sim.sv */
// Set-associative cache hit/miss model, most-recently-used replacement. Each input beat
// (op in s_tuser, address in s_tdata) makes one access, or two for a modify; op 3 makes none.
// One access reads the set's whole row from a single ram (all ways: valid, tag, stamp),
// compares the ways and writes the row back; when the set is full, the most recent stamp is
// found by scanning the row, one way in use at a time, before the write-back.
// An access waits before its row read until the previous result beat has left the output
// register, and a new input beat is accepted while that beat still waits. After reset a
// clearing pass writes zero to all 2^MAX_SET_BITS rows, wiping the valid bits, before the
// first input beat is taken; configuration writes are taken at any time.
// Depends on sacm_pkg and sacm_ram.
`default_nettype none

module set_assoc_cache_mru_sim
	import sacm_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,

	// configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,

	// access beats
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [ADDR_FIELD_W-1:0] s_tdata,   // [63:0] address
	input  logic [OP_W-1:0]         s_tuser,   // [1:0] op

	// result beats
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [TOTALS_W-1:0]     m_tdata,   // [31:0] hit_total, [63:32] miss_total,
	                                           // [95:64] eviction_total
	output logic [FLAGS_W-1:0]      m_tuser,   // [0] hit, [1] miss, [2] evicted
	output logic                    m_tlast    // last
);

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int WX_W   = (WCNT_W > WAYS_W) ? WCNT_W : WAYS_W;
	localparam int SBC_W  = $clog2(MAX_SET_BITS + 1);
	localparam int SB_W   = (SBC_W > SET_BITS_W) ? SBC_W : SET_BITS_W;
	localparam int SH_W   = 8;

	typedef struct packed {
		logic                  valid;
		logic [ADDR_WIDTH-1:0] tag;
		logic [STAMP_W-1:0]    stamp;
	} line_t;

	localparam int ROW_W = MAX_WAYS * $bits(line_t);

	// sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
	endfunction

	// control state
	logic [2:0]               state_q;
	logic [SET_W-1:0]         clr_cnt_q;
	logic                     pass_q;
	logic [STAMP_W-1:0]       stamp_ctr_q;
	logic [TOTAL_W-1:0]       hits_q;
	logic [TOTAL_W-1:0]       misses_q;
	logic [TOTAL_W-1:0]       evicts_q;
	logic [SET_BITS_W-1:0]    set_bits_q;
	logic [OFFSET_BITS_W-1:0] offset_bits_q;
	logic [WAYS_W-1:0]        ways_q;
	logic                     m_tvalid_q;

	// access payload
	logic [OP_W-1:0]          op_q;
	logic [ADDR_WIDTH-1:0]    addr_q;
	logic [ADDR_WIDTH-1:0]    tag_q;
	logic [SET_W-1:0]         set_q;
	logic [WAY_W-1:0]         pick_q;
	logic [WAY_W-1:0]         scan_q;
	logic [STAMP_W-1:0]       best_q;
	logic                     hit_q;
	logic                     evict_q;
	logic [TOTALS_W-1:0]      m_tdata_q;
	logic [FLAGS_W-1:0]       m_tuser_q;
	logic                     m_tlast_q;

	// ram port
	logic                     ram_we;
	logic [SET_W-1:0]         ram_waddr;
	logic [ROW_W-1:0]         ram_wdata;
	logic                     ram_re;
	logic [ROW_W-1:0]         ram_rdata;

	line_t [MAX_WAYS-1:0]     row_rd;
	line_t [MAX_WAYS-1:0]     row_wr;

	// address split
	logic [SB_W-1:0]          sb_ext;
	logic [SB_W-1:0]          sb_c;
	logic [SET_W:0]           mask_wide;
	logic [ADDR_WIDTH-1:0]    off_shifted;
	logic [SET_W-1:0]         set_c;
	logic [ADDR_WIDTH-1:0]    tag_c;
	logic [SH_W-1:0]          tag_sh;

	// way limits and search
	logic [WX_W-1:0]          ways_ext;
	logic [WX_W-1:0]          ways_lim;
	logic                     hit_found;
	logic [WAY_W-1:0]         hit_way;
	logic                     inv_found;
	logic [WAY_W-1:0]         inv_way;
	logic [STAMP_W-1:0]       scan_stamp;
	logic                     scan_done;

	logic                     last_c;
	logic                     out_free;
	logic                     rd_go;
	logic [TOTAL_W-1:0]       hits_nx;
	logic [TOTAL_W-1:0]       misses_nx;
	logic [TOTAL_W-1:0]       evicts_nx;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign rd_go     = (state_q == ST_RD) && out_free;
	assign last_c    = !((op_q == OP_MODIFY) && !pass_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// clamp set bits and way count to what the storage holds; a way count of zero counts as one
	always_comb begin
		sb_ext   = SB_W'(set_bits_q);
		sb_c     = (sb_ext > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : sb_ext;
		ways_ext = WX_W'(ways_q);
		if (ways_ext == '0) begin
			ways_lim = WX_W'(1);
		end else if (ways_ext > WX_W'(MAX_WAYS)) begin
			ways_lim = WX_W'(MAX_WAYS);
		end else begin
			ways_lim = ways_ext;
		end
	end

	// set index and tag from the held address; over-wide shifts give zero
	always_comb begin
		mask_wide   = ((SET_W + 1)'(1) << sb_c) - (SET_W + 1)'(1);
		off_shifted = addr_q >> offset_bits_q;
		set_c       = off_shifted[SET_W-1:0] & mask_wide[SET_W-1:0];
		tag_sh      = SH_W'(offset_bits_q) + SH_W'(sb_c);
		tag_c       = addr_q >> tag_sh;
	end

	assign row_rd = ram_rdata;

	// first matching way and first free way among the ways in use
	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WX_W'(w) < ways_lim) begin
				if (!hit_found && row_rd[w].valid && (row_rd[w].tag == tag_q)) begin
					hit_found = 1'b1;
					hit_way   = WAY_W'(w);
				end
				if (!inv_found && !row_rd[w].valid) begin
					inv_found = 1'b1;
					inv_way   = WAY_W'(w);
				end
			end
		end
	end

	// one way of the stamp scan per cycle
	assign scan_stamp = row_rd[scan_q].stamp;
	assign scan_done  = (WX_W'(scan_q) == (ways_lim - WX_W'(1)));

	// write-back row: the picked way takes the tag and a fresh stamp
	always_comb begin
		row_wr                = row_rd;
		row_wr[pick_q].valid  = 1'b1;
		row_wr[pick_q].tag    = tag_q;
		row_wr[pick_q].stamp  = stamp_ctr_q;
	end

	// ram port muxing between the clearing pass and the write-back
	always_comb begin
		ram_re    = rd_go;
		ram_we    = 1'b0;
		ram_waddr = set_q;
		ram_wdata = row_wr;
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (state_q == ST_WR) begin
			ram_we = 1'b1;
		end
	end

	sacm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (set_c),
		.rdata (ram_rdata)
	);

	// running totals after this access
	always_comb begin
		hits_nx   = hit_q ? sat_inc(hits_q) : hits_q;
		misses_nx = hit_q ? misses_q : sat_inc(misses_q);
		evicts_nx = evict_q ? sat_inc(evicts_q) : evicts_q;
	end

	// sequencer, totals, stamp counter and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			clr_cnt_q     <= '0;
			pass_q        <= 1'b0;
			stamp_ctr_q   <= STAMP_W'(1);
			hits_q        <= '0;
			misses_q      <= '0;
			evicts_q      <= '0;
			set_bits_q    <= '0;
			offset_bits_q <= '0;
			ways_q        <= WAYS_W'(1);
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SET_BITS:    set_bits_q    <= cfg_data[SET_BITS_W-1:0];
					CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OFFSET_BITS_W-1:0];
					CFG_WAYS:        ways_q        <= cfg_data[WAYS_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_WR) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + SET_W'(1);
					if (clr_cnt_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && (s_tuser != OP_UNUSED)) begin
						pass_q  <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (out_free) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (hit_found || inv_found) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					stamp_ctr_q <= stamp_ctr_q + STAMP_W'(1);
					hits_q      <= hits_nx;
					misses_q    <= misses_nx;
					evicts_q    <= evicts_nx;
					if (last_c) begin
						state_q <= ST_IDLE;
					end else begin
						pass_q  <= 1'b1;
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// access payload and result beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			addr_q <= s_tdata[ADDR_WIDTH-1:0];
		end
		if (rd_go) begin
			tag_q <= tag_c;
			set_q <= set_c;
		end
		if (state_q == ST_CMP) begin
			hit_q   <= hit_found;
			evict_q <= !hit_found && !inv_found;
			scan_q  <= '0;
			best_q  <= '0;
			if (hit_found) begin
				pick_q <= hit_way;
			end else if (inv_found) begin
				pick_q <= inv_way;
			end else begin
				pick_q <= '0;
			end
		end
		if (state_q == ST_SCAN) begin
			scan_q <= scan_q + WAY_W'(1);
			if (scan_stamp > best_q) begin
				best_q <= scan_stamp;
				pick_q <= scan_q;
			end
		end
		if (state_q == ST_WR) begin
			m_tdata_q             <= {evicts_nx, misses_nx, hits_nx};
			m_tuser_q[FLAG_HIT]   <= hit_q;
			m_tuser_q[FLAG_MISS]  <= !hit_q;
			m_tuser_q[FLAG_EVICT] <= evict_q;
			m_tlast_q             <= last_c;
		end
	end

endmodule

`default_nettype wire

/* src/sacm_checker.sv */
// port-level checks of the cache model: result flags, totals and beat bookkeeping
// depends on sacm_pkg and assert_macros.svh; bound to set_assoc_cache_mru_sim below
`default_nettype none

`include "assert_macros.svh"

module sacm_checker
	import sacm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [OP_W-1:0]     s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [TOTALS_W-1:0] m_tdata,
	input  logic [FLAGS_W-1:0]  m_tuser,
	input  logic                m_tlast
);

	logic [TOTAL_W-1:0] hit_tot;
	logic [TOTAL_W-1:0] miss_tot;
	logic [TOTAL_W-1:0] evict_tot;
	logic [TOTAL_W-1:0] prev_hit_q;
	logic [TOTAL_W-1:0] prev_miss_q;
	logic [TOTAL_W-1:0] prev_evict_q;
	logic [1:0]         pend_q;
	logic               in_beat;
	logic               out_beat;
	logic               hit_ok;
	logic               miss_ok;
	logic               evict_ok;

	assign hit_tot   = m_tdata[0*TOTAL_W +: TOTAL_W];
	assign miss_tot  = m_tdata[1*TOTAL_W +: TOTAL_W];
	assign evict_tot = m_tdata[2*TOTAL_W +: TOTAL_W];
	assign in_beat   = s_tvalid && s_tready && (s_tuser != OP_UNUSED);
	assign out_beat  = m_tvalid && m_tready;

	// each total moves by its flag from the previous beat, or stays saturated
	assign hit_ok = ((prev_hit_q == TOTAL_MAX) && (hit_tot == TOTAL_MAX)) ||
		(hit_tot == prev_hit_q + TOTAL_W'(m_tuser[FLAG_HIT]));
	assign miss_ok = ((prev_miss_q == TOTAL_MAX) && (miss_tot == TOTAL_MAX)) ||
		(miss_tot == prev_miss_q + TOTAL_W'(m_tuser[FLAG_MISS]));
	assign evict_ok = ((prev_evict_q == TOTAL_MAX) && (evict_tot == TOTAL_MAX)) ||
		(evict_tot == prev_evict_q + TOTAL_W'(m_tuser[FLAG_EVICT]));

	// totals of the last delivered beat and items still owed a last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hit_q   <= '0;
			prev_miss_q  <= '0;
			prev_evict_q <= '0;
			pend_q       <= '0;
		end else begin
			if (out_beat) begin
				prev_hit_q   <= hit_tot;
				prev_miss_q  <= miss_tot;
				prev_evict_q <= evict_tot;
			end
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat && m_tlast);
		end
	end

	`SACM_ASSERT_IMP(a_flags, m_tvalid, ((m_tuser[FLAG_HIT] ^ m_tuser[FLAG_MISS]) && (!m_tuser[FLAG_EVICT] || m_tuser[FLAG_MISS])), "result flags inconsistent")
	`SACM_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
	`SACM_ASSERT_IMP(a_owed, out_beat, pend_q != 2'd0, "result beat without an open access item")
	`SACM_ASSERT_IMP(a_hit_total, out_beat, hit_ok, "hit total does not follow the hit flag")
	`SACM_ASSERT_IMP(a_miss_evict_total, out_beat, miss_ok && evict_ok, "miss or eviction total does not follow its flag")

endmodule

bind set_assoc_cache_mru_sim sacm_checker u_sacm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
